[hdl/lfu_pkg.sv]
`default_nettype none
package lfu_pkg;

   localparam int CAPACITY_DEF   = 16;
   localparam int COUNT_BITS_DEF = 16;
   localparam int DATA_W         = 32;
   localparam int CSR_W          = 5;

   localparam logic [CSR_W-1:0]  CAPACITY_RESET = CSR_W'(16);
   localparam logic [DATA_W-1:0] MISS_VALUE     = '1;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef struct packed {
      logic                     operation;
      logic signed [DATA_W-1:0] lookup_key;
      logic signed [DATA_W-1:0] store_value;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] read_value;
   } rsp_type;

endpackage
`default_nettype wire

[hdl/lfu_ram.sv]
`default_nettype none
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [AW-1:0]            wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [AW-1:0]            rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

[hdl/lfu_cache_lru_tiebreak_unit.sv]
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  lfu_pkg::req_type (operation, key, value)
// rsp      out        rsp_valid/rsp_ready  lfu_pkg::rsp_type (hit, read_value)
// csr      in         csr_valid/csr_ready  capacity in use, 5 bits
//
// One item at a time: a scan pass reads every entry of the entry RAM
// through its registered read port, then a decide state; for a hit or an
// insert an update pass reads every entry again and writes back those that
// change, and last an output state loads the output register. With no hit
// and no insert the update pass is skipped. The next item is taken once the
// output register is loaded. The entry RAM has a single read port. Reset is
// synchronous; it empties the cache through the valid flops. A stalled result
// holds in the output register while the next item is already taken.
`default_nettype none
module lfu_cache_lru_tiebreak_unit #(
   parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
   parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire lfu_pkg::req_type          req_data,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   output      lfu_pkg::rsp_type          rsp_data,
   input  wire logic                      csr_valid,
   output      logic                      csr_ready,
   input  wire logic [lfu_pkg::CSR_W-1:0] csr_data
);
   import lfu_pkg::*;

   localparam int IW = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int MW = CW > CSR_W ? CW : CSR_W;
   localparam int EW = 2 * DATA_W + COUNT_BITS + IW;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
   localparam logic [CW-1:0]         IDX_END = CW'(CAPACITY);
   localparam logic [MW-1:0]         CAP_MAX = MW'(CAPACITY);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_UPD    = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   logic [2:0]            state_ff, state_in;
   req_type               req_ff, req_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [IW-1:0]         pend_idx_ff, pend_idx_in;
   logic                  found_ff, found_in;
   logic [IW-1:0]         found_idx_ff, found_idx_in;
   logic [IW-1:0]         found_rank_ff, found_rank_in;
   logic [DATA_W-1:0]     found_val_ff, found_val_in;
   logic                  vict_ff, vict_in;
   logic [IW-1:0]         vict_idx_ff, vict_idx_in;
   logic [COUNT_BITS-1:0] vict_cnt_ff, vict_cnt_in;
   logic [IW-1:0]         vict_rank_ff, vict_rank_in;
   logic                  free_ff, free_in;
   logic [IW-1:0]         free_idx_ff, free_idx_in;
   logic                  bump_ff, bump_in;
   logic                  ins_ff, ins_in;
   logic                  evict_ff, evict_in;
   logic [IW-1:0]         slot_ff, slot_in;
   logic [CAPACITY-1:0]   valid_ff, valid_in;
   logic [CW-1:0]         occ_ff, occ_in;
   logic [CSR_W-1:0]      cap_ff, cap_in;
   rsp_type               res_ff, res_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  ram_we;
   logic [EW-1:0]         ram_wdata, ram_rdata;
   logic [DATA_W-1:0]     d_key, d_val;
   logic [COUNT_BITS-1:0] d_cnt;
   logic [IW-1:0]         d_rank;
   logic                  d_vld;
   logic                  idx_live;
   logic [MW-1:0]         cap_eff;
   logic                  do_evict;
   logic [IW-1:0]         new_rank;
   logic [COUNT_BITS-1:0] new_cnt;
   logic [DATA_W-1:0]     new_val;

   // entry RAM: key, value, use count, recency rank
   lfu_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pend_idx_ff),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (ram_rdata)
   );

   assign d_key  = ram_rdata[EW-1 -: DATA_W];
   assign d_val  = ram_rdata[EW-DATA_W-1 -: DATA_W];
   assign d_cnt  = ram_rdata[IW +: COUNT_BITS];
   assign d_rank = ram_rdata[IW-1:0];
   assign d_vld  = valid_ff[pend_idx_ff];
   assign idx_live = idx_ff < IDX_END;

   assign cap_eff  = (MW'(cap_ff) > CAP_MAX) ? CAP_MAX : MW'(cap_ff);
   assign do_evict = (MW'(occ_ff) >= cap_eff) && (occ_ff != '0) && vict_ff;

   assign req_ready = state_ff == S_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // write-back data for the update pass
   always_comb begin
      ram_we    = 1'b0;
      new_rank  = d_rank;
      new_cnt   = d_cnt;
      new_val   = d_val;
      ram_wdata = ram_rdata;
      if (state_ff == S_UPD && pend_ff) begin
         if (bump_ff) begin
            if (pend_idx_ff == found_idx_ff) begin
               ram_we   = 1'b1;
               new_rank = '0;
               new_cnt  = (d_cnt == CNT_MAX) ? d_cnt : d_cnt + CNT_ONE;
               if (req_ff.operation == OP_PUT) begin
                  new_val = req_ff.store_value;
               end
            end else if (d_vld && d_rank < found_rank_ff) begin
               ram_we   = 1'b1;
               new_rank = d_rank + IW'(1);
            end
            ram_wdata = {d_key, new_val, new_cnt, new_rank};
         end else if (ins_ff) begin
            if (pend_idx_ff == slot_ff) begin
               ram_we    = 1'b1;
               ram_wdata = {req_ff.lookup_key, req_ff.store_value, CNT_ONE, IW'(0)};
            end else if (d_vld && !(evict_ff && pend_idx_ff == vict_idx_ff)
                         && !(evict_ff && d_rank > vict_rank_ff)) begin
               // not older than the victim: move back one rank; older ones keep theirs
               ram_we    = 1'b1;
               ram_wdata = {d_key, d_val, d_cnt, d_rank + IW'(1)};
            end
         end
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      pend_idx_in   = idx_ff[IW-1:0];
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_rank_in = found_rank_ff;
      found_val_in  = found_val_ff;
      vict_in       = vict_ff;
      vict_idx_in   = vict_idx_ff;
      vict_cnt_in   = vict_cnt_ff;
      vict_rank_in  = vict_rank_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      bump_in       = bump_ff;
      ins_in        = ins_ff;
      evict_in      = evict_ff;
      slot_in       = slot_ff;
      valid_in      = valid_ff;
      occ_in        = occ_ff;
      cap_in        = csr_valid ? csr_data : cap_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               idx_in   = '0;
               found_in = 1'b0;
               vict_in  = 1'b0;
               free_in  = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (idx_live) begin
               pend_in = 1'b1;
               idx_in  = idx_ff + CW'(1);
            end
            if (pend_ff) begin
               if (d_vld && d_key == req_ff.lookup_key) begin
                  found_in      = 1'b1;
                  found_idx_in  = pend_idx_ff;
                  found_rank_in = d_rank;
                  found_val_in  = d_val;
               end
               if (d_vld && (!vict_ff || d_cnt < vict_cnt_ff ||
                             (d_cnt == vict_cnt_ff && d_rank > vict_rank_ff))) begin
                  vict_in      = 1'b1;
                  vict_idx_in  = pend_idx_ff;
                  vict_cnt_in  = d_cnt;
                  vict_rank_in = d_rank;
               end
               if (!d_vld && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = pend_idx_ff;
               end
            end
            if (!idx_live && !pend_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            bump_in  = 1'b0;
            ins_in   = 1'b0;
            evict_in = 1'b0;
            slot_in  = free_idx_ff;
            res_in.hit        = found_ff;
            res_in.read_value = (req_ff.operation == OP_GET && found_ff) ?
                                found_val_ff : MISS_VALUE;
            if (req_ff.operation == OP_GET) begin
               bump_in = found_ff;
            end else if (cap_eff != '0) begin
               if (found_ff) begin
                  bump_in = 1'b1;
               end else begin
                  evict_in = do_evict;
                  if (do_evict && !(free_ff && free_idx_ff < vict_idx_ff)) begin
                     slot_in = vict_idx_ff;
                  end
                  ins_in = do_evict || free_ff;
               end
            end
            idx_in   = '0;
            state_in = (bump_in || ins_in) ? S_UPD : S_OUT;
         end
         S_UPD: begin
            if (idx_live) begin
               pend_in = 1'b1;
               idx_in  = idx_ff + CW'(1);
            end
            if (!idx_live && !pend_ff) begin
               if (ins_ff) begin
                  if (evict_ff) begin
                     valid_in[vict_idx_ff] = 1'b0;
                  end else begin
                     occ_in = occ_ff + CW'(1);
                  end
                  valid_in[slot_ff] = 1'b1;
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         cap_ff       <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      pend_idx_ff   <= pend_idx_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      found_rank_ff <= found_rank_in;
      found_val_ff  <= found_val_in;
      vict_ff       <= vict_in;
      vict_idx_ff   <= vict_idx_in;
      vict_cnt_ff   <= vict_cnt_in;
      vict_rank_ff  <= vict_rank_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      bump_ff       <= bump_in;
      ins_ff        <= ins_in;
      evict_ff      <= evict_in;
      slot_ff       <= slot_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end
endmodule
`default_nettype wire

[hdl/lfu_checker.sv]
`default_nettype none
module lfu_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire lfu_pkg::rsp_type          rsp_data
);
   import lfu_pkg::*;

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one item at a time: busy after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken without a scan");

   // every miss reads as minus one
   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.read_value == MISS_VALUE)
      else $error("miss without minus one");
endmodule

bind lfu_cache_lru_tiebreak_unit lfu_checker u_lfu_checker (.*);
`default_nettype wire
